[hw/rtl/tksm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the top-k sum multiset block.
// No dependencies; used by tksm_cell and top_k_sum_multiset.
package tksm_pkg;

	// default sizes of the store
	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths of the channels
	localparam int IN_VALUE_BITS  = 32;
	localparam int SUM_BITS       = 38;
	localparam int CNT_BITS       = 7;
	localparam int CFG_BITS       = 7;
	localparam int STATUS_BITS    = 2;
	localparam int OUT_TDATA_BITS = 48;

	// func codes on the input tuser
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// operation broadcast to the cells while a wave runs
	typedef enum logic [1:0] {
		OP_NOP = 2'd0,
		OP_INS = 2'd1,
		OP_REM = 2'd2
	} tksm_op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} tksm_status_t;

	// flags that travel with the update wave from cell to cell
	typedef struct packed {
		logic active;    // wave is at this cell
		logic found;     // remove: matching entry seen at or before this cell
		logic carry_on;  // insert: a value is still being carried down
	} tksm_wave_t;

endpackage

[hw/rtl/top_k_sum_multiset.sv]
`timescale 1ns / 1ps
// Top level of the top-k sum multiset: handshakes, item control and the cell chain.
// Depends on tksm_pkg and tksm_cell.
//
// Keeps a multiset of signed values sorted in descending order in a chain of
// CAPACITY cells. Each input item (s_tuser = func, s_tdata = value) inserts or
// removes one occurrence of a value. Each item gives one result item on the
// master side: the sum of the top_count largest values held, the count held
// and a status (ok, store full and insert dropped, value not found).
//
// An accepted item launches an update wave into cell 0. The wave moves one
// cell per cycle, updates each entry from its neighbors and accumulates the
// sum on the way, so the chain length sets the timing. m_tvalid and s_tready
// rise together, when the result moves to the output register; the block
// finishes one item before it takes the next. s_tready is low
// while an item is at work.
// A stalled receiver holds the result in the output register; a finished
// result waits in a holding register and the block takes no new item until
// that result moves out.
// Reset empties the store, sets top_count to 1 and drops any
// item at work. Write top_count only while the block is idle.
module top_k_sum_multiset #(
	parameter int CAPACITY   = tksm_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = tksm_pkg::VALUE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input items
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [tksm_pkg::IN_VALUE_BITS-1:0]     s_tdata,   // [31:0] value
	input  logic                                   s_tuser,   // [0] func
	// result items
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [tksm_pkg::OUT_TDATA_BITS-1:0]    m_tdata,   // [37:0] top_sum, [44:38] held_count
	output logic [tksm_pkg::STATUS_BITS-1:0]       m_tuser,   // [1:0] status
	// configuration
	input  logic                                   top_count_we,
	input  logic [tksm_pkg::CFG_BITS-1:0]          top_count_wdata
);

	localparam int SumW    = tksm_pkg::SUM_BITS;
	localparam int CntBits = tksm_pkg::CNT_BITS;
	localparam int CfgBits = tksm_pkg::CFG_BITS;
	localparam int PadBits = tksm_pkg::OUT_TDATA_BITS - SumW - CntBits;
	localparam int CntW    = $clog2(CAPACITY + 1);
	localparam int LimW    = (CntW > CfgBits) ? CntW : CfgBits;

	// control state
	logic                         busy_q;
	logic                         launch_q;
	logic                         pend_v_q;
	logic                         m_tvalid_q;
	logic [CntW-1:0]              count_q;
	logic [CfgBits-1:0]           top_count_q;
	tksm_pkg::tksm_op_t           op_q;

	// payload
	logic signed [VALUE_BITS-1:0] key_q;
	logic signed [SumW-1:0]       pend_sum_q;
	logic [CntW-1:0]              pend_cnt_q;
	tksm_pkg::tksm_status_t       pend_status_q;
	logic signed [SumW-1:0]       out_sum_q;
	logic [CntW-1:0]              out_cnt_q;
	tksm_pkg::tksm_status_t       out_status_q;

	// chain links, index i feeds cell i
	tksm_pkg::tksm_wave_t         wave [0:CAPACITY];
	logic signed [VALUE_BITS-1:0] carry [0:CAPACITY];
	logic signed [SumW-1:0]       sum [0:CAPACITY];
	logic signed [VALUE_BITS-1:0] cell_val [0:CAPACITY];

	logic                         accept;
	logic                         done;
	logic                         out_load;
	logic [CntW-1:0]              count_next;
	tksm_pkg::tksm_status_t       status_next;
	tksm_pkg::tksm_op_t           op_next;
	logic [LimW-1:0]              k_lim;
	logic [LimW-1:0]              count_lim;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign done     = wave[CAPACITY].active;
	assign out_load = pend_v_q && (!m_tvalid_q || m_tready);

	// a full store turns an insert into a pass that only sums
	always_comb begin
		if (s_tuser == tksm_pkg::FUNC_REMOVE) begin
			op_next = tksm_pkg::OP_REM;
		end else if (count_q == CntW'(CAPACITY)) begin
			op_next = tksm_pkg::OP_NOP;
		end else begin
			op_next = tksm_pkg::OP_INS;
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = tksm_pkg::ST_OK;
		case (op_q)
			tksm_pkg::OP_INS: begin
				count_next = count_q + CntW'(1);
			end
			tksm_pkg::OP_REM: begin
				if (wave[CAPACITY].found) begin
					count_next = count_q - CntW'(1);
				end else begin
					status_next = tksm_pkg::ST_MISSING;
				end
			end
			default: begin
				status_next = tksm_pkg::ST_FULL;
			end
		endcase
	end

	// limits for the cells: count_q holds while the wave runs, top_count_q only if written while idle
	assign k_lim     = LimW'(top_count_q);
	assign count_lim = LimW'(count_q);

	// launch into cell 0
	assign wave[0]           = '{active: launch_q, found: 1'b0,
		carry_on: (op_q == tksm_pkg::OP_INS)};
	assign carry[0]          = key_q;
	assign sum[0]            = {SumW{1'b0}};
	assign cell_val[CAPACITY] = {VALUE_BITS{1'b0}};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		tksm_cell #(
			.VAL_W (VALUE_BITS),
			.LIM_W (LimW),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op_q),
			.key       (key_q),
			.count     (count_lim),
			.k_lim     (k_lim),
			.wave_in   (wave[i]),
			.carry_in  (carry[i]),
			.sum_in    (sum[i]),
			.next_val  (cell_val[i+1]),
			.val       (cell_val[i]),
			.wave_out  (wave[i+1]),
			.carry_out (carry[i+1]),
			.sum_out   (sum[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			count_q     <= '0;
			top_count_q <= CfgBits'(1);
			op_q        <= tksm_pkg::OP_NOP;
		end else begin
			launch_q <= accept;
			if (top_count_we) begin
				top_count_q <= top_count_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
				op_q   <= op_next;
			end
			// wave leaves the last cell: commit the count, park the result
			if (done) begin
				pend_v_q <= 1'b1;
				count_q  <= count_next;
			end
			if (out_load) begin
				pend_v_q   <= 1'b0;
				busy_q     <= 1'b0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= VALUE_BITS'(s_tdata);
		end
		if (done) begin
			pend_sum_q    <= sum[CAPACITY];
			pend_cnt_q    <= count_next;
			pend_status_q <= status_next;
		end
		if (out_load) begin
			out_sum_q    <= pend_sum_q;
			out_cnt_q    <= pend_cnt_q;
			out_status_q <= pend_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PadBits{1'b0}}, CntBits'(out_cnt_q), out_sum_q};
	assign m_tuser  = out_status_q;

	// the wave only leaves the chain for an item at work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("wave finished with no item at work");

	// a wave starts only right after an item is taken
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> $past(accept))
		else $error("wave launched without an accepted item");

	// the count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("held count above capacity");

	// a dropped insert only happens on a full store, and leaves it full
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == tksm_pkg::OP_NOP) |=> (count_q == CntW'(CAPACITY)))
		else $error("insert dropped on a store that is not full");

	// a parked result never outlives its item
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> busy_q)
		else $error("result parked while idle");

endmodule

[hw/rtl/tksm_cell.sv]
`timescale 1ns / 1ps
// One entry of the sorted chain: holds a value, updates it when the wave passes.
// Depends on tksm_pkg.
module tksm_cell #(
	parameter int VAL_W = tksm_pkg::VALUE_BITS_DEF,
	parameter int LIM_W = tksm_pkg::CFG_BITS,
	parameter int IDX   = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tksm_pkg::tksm_op_t                    op,
	input  logic signed [VAL_W-1:0]               key,
	input  logic        [LIM_W-1:0]               count,
	input  logic        [LIM_W-1:0]               k_lim,
	input  tksm_pkg::tksm_wave_t                  wave_in,
	input  logic signed [VAL_W-1:0]               carry_in,
	input  logic signed [tksm_pkg::SUM_BITS-1:0]  sum_in,
	input  logic signed [VAL_W-1:0]               next_val,
	output logic signed [VAL_W-1:0]               val,
	output tksm_pkg::tksm_wave_t                  wave_out,
	output logic signed [VAL_W-1:0]               carry_out,
	output logic signed [tksm_pkg::SUM_BITS-1:0]  sum_out
);

	localparam int SumW = tksm_pkg::SUM_BITS;
	localparam logic [LIM_W-1:0] IdxL    = LIM_W'(IDX);
	localparam logic [LIM_W-1:0] IdxNext = LIM_W'(IDX + 1);

	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] new_val;
	logic signed [VAL_W-1:0] carry_n;
	logic signed [VAL_W-1:0] carry_q;
	logic signed [SumW-1:0]  sum_n;
	logic signed [SumW-1:0]  sum_q;
	tksm_pkg::tksm_wave_t    wave_n;
	tksm_pkg::tksm_wave_t    wave_q;
	logic                    occ;
	logic                    incl;

	assign occ = IdxL < count;

	always_comb begin
		new_val = val_q;
		carry_n = carry_in;
		wave_n  = wave_in;
		incl    = 1'b0;
		case (op)
			tksm_pkg::OP_INS: begin
				// place into the first free cell, or swap past smaller values
				if (wave_in.carry_on) begin
					if (!occ) begin
						new_val         = carry_in;
						wave_n.carry_on = 1'b0;
					end else if (carry_in > val_q) begin
						new_val = carry_in;
						carry_n = val_q;
					end
				end
				incl = (IdxL < k_lim) && (IdxL <= count);
			end
			tksm_pkg::OP_REM: begin
				// from the first match on, pull the right neighbor in
				wave_n.found = wave_in.found | (occ && (val_q == key));
				if (wave_n.found) begin
					new_val = next_val;
				end
				incl = (IdxL < k_lim) && (wave_n.found ? (IdxNext < count) : (IdxL < count));
			end
			default: begin
				incl = (IdxL < k_lim) && (IdxL < count);
			end
		endcase
		sum_n = sum_in + (incl ? SumW'(new_val) : {SumW{1'b0}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wave_in.active) begin
			val_q <= new_val;
		end
		carry_q <= carry_n;
		sum_q   <= sum_n;
	end

	assign val       = val_q;
	assign wave_out  = wave_q;
	assign carry_out = carry_q;
	assign sum_out   = sum_q;

endmodule

[verif/tb_top_k_sum_multiset.sv]
`timescale 1ns / 1ps
// Self-checking bench for top_k_sum_multiset: directed and random insert/remove items.
// Tracks the sorted multiset and its top-k sum in the bench itself; needs tksm_pkg and the RTL.
module testbench;

	localparam int DEPTH        = tksm_pkg::CAPACITY_DEF;
	// no item moves for this many cycles: the block is hung
	localparam int STALL_LIMIT  = 4000;
	// one full wave through the cell chain plus margin
	localparam int DRAIN_CYCLES = tksm_pkg::CAPACITY_DEF + 8;
	localparam int PRINT_LIMIT  = 50;

	localparam logic [tksm_pkg::IN_VALUE_BITS-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [tksm_pkg::IN_VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

	typedef struct {
		logic [tksm_pkg::SUM_BITS-1:0] top_sum;
		logic [tksm_pkg::CNT_BITS-1:0] held_count;
		tksm_pkg::tksm_status_t        status;
	} sum_result_t;

	// Mirror of the store: descending values, count held and the current k.
	// Every accepted input item queues the result it must produce.
	class multiset_tracker;
		logic signed [tksm_pkg::IN_VALUE_BITS-1:0] ranked[DEPTH];
		int                                        held_n;
		int                                        top_k;
		int                                        fail_count;
		sum_result_t                               awaited_sums[$];

		function new();
			held_n     = 0;
			top_k      = 1;
			fail_count = 0;
		endfunction

		task report(input string what);
			if (fail_count < PRINT_LIMIT) begin
				$display("%0t mismatch: %s", $time, what);
			end
			fail_count++;
		endtask

		function void note_item(input logic func,
				input logic [tksm_pkg::IN_VALUE_BITS-1:0] raw);
			logic signed [tksm_pkg::IN_VALUE_BITS-1:0] v;
			sum_result_t                               want;
			int                                        pos;
			int                                        lim;
			longint                                    acc;
			v = raw;
			want.status = tksm_pkg::ST_OK;
			pos = 0;
			if (func == tksm_pkg::FUNC_INSERT) begin
				if (held_n >= DEPTH) begin
					want.status = tksm_pkg::ST_FULL;
				end else begin
					// equal values stay ahead of the new one
					while (pos < held_n && ranked[pos] >= v) pos++;
					for (int i = held_n; i > pos; i--) ranked[i] = ranked[i-1];
					ranked[pos] = v;
					held_n++;
				end
			end else begin
				while (pos < held_n && ranked[pos] != v) pos++;
				if (pos >= held_n) begin
					want.status = tksm_pkg::ST_MISSING;
				end else begin
					for (int i = pos; i < held_n - 1; i++) ranked[i] = ranked[i+1];
					held_n--;
				end
			end
			// k above the count held sums everything, k of zero sums nothing
			lim = (top_k < held_n) ? top_k : held_n;
			acc = 0;
			for (int i = 0; i < lim; i++) acc += ranked[i];
			want.top_sum    = acc[tksm_pkg::SUM_BITS-1:0];
			want.held_count = tksm_pkg::CNT_BITS'(held_n);
			awaited_sums.push_back(want);
		endfunction

		task check_result(input logic [tksm_pkg::OUT_TDATA_BITS-1:0] tdata,
				input logic [tksm_pkg::STATUS_BITS-1:0] tuser);
			sum_result_t want;
			if (awaited_sums.size() == 0) begin
				report($sformatf("result with no item waiting, tdata %h", tdata));
			end else begin
				want = awaited_sums.pop_front();
				if (tdata[tksm_pkg::SUM_BITS-1:0] !== want.top_sum)
					report($sformatf("top_sum %h, want %h",
						tdata[tksm_pkg::SUM_BITS-1:0], want.top_sum));
				if (tdata[tksm_pkg::SUM_BITS+tksm_pkg::CNT_BITS-1:tksm_pkg::SUM_BITS]
						!== want.held_count)
					report($sformatf("held_count %0d, want %0d",
						tdata[tksm_pkg::SUM_BITS+tksm_pkg::CNT_BITS-1:tksm_pkg::SUM_BITS],
						want.held_count));
				if (tuser !== want.status)
					report($sformatf("status %0d, want %0d", tuser, want.status));
			end
		endtask
	endclass

	logic                                    clk             = 1'b0;
	logic                                    arst_n          = 1'b0;
	logic                                    s_tvalid        = 1'b0;
	logic                                    s_tready;
	logic [tksm_pkg::IN_VALUE_BITS-1:0]      s_tdata         = '0;
	logic                                    s_tuser         = tksm_pkg::FUNC_INSERT;
	logic                                    m_tvalid;
	logic                                    m_tready        = 1'b0;
	logic [tksm_pkg::OUT_TDATA_BITS-1:0]     m_tdata;
	logic [tksm_pkg::STATUS_BITS-1:0]        m_tuser;
	logic                                    top_count_we    = 1'b0;
	logic [tksm_pkg::CFG_BITS-1:0]           top_count_wdata = '0;

	multiset_tracker tracker;
	int              send_idle_pct = 14;
	int              recv_idle_pct = 65;
	int              quiet_cycles  = 0;

	top_k_sum_multiset i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),          // [31:0] value
		.s_tuser         (s_tuser),          // [0] func
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),          // [37:0] top_sum, [44:38] held_count
		.m_tuser         (m_tuser),          // [1:0] status
		.top_count_we    (top_count_we),
		.top_count_wdata (top_count_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each accepted item, stall at random, and watch for a hang.
	// Handshake signals read here are the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_result(m_tdata, m_tuser);
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("top_k_sum_multiset regression: fail");
			$finish;
		end
	end

	// Present one item, after a random idle gap, and hold it until accepted.
	// Returns in the time step of the accepting edge with tvalid still high.
	task automatic send_item(input logic func,
			input logic [tksm_pkg::IN_VALUE_BITS-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(func, value);
	endtask

	// Drop tvalid and hold until every queued result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.awaited_sums.size() != 0) @(posedge clk);
	endtask

	task automatic write_top_count(input int k);
		wait_drained();
		top_count_we    <= 1'b1;
		top_count_wdata <= tksm_pkg::CFG_BITS'(k);
		@(posedge clk);
		top_count_we    <= 1'b0;
		tracker.top_k = k;
	endtask

	// Mostly full-range values; a small pool around zero makes duplicates.
	function automatic logic [tksm_pkg::IN_VALUE_BITS-1:0] pick_value();
		logic [tksm_pkg::IN_VALUE_BITS-1:0] v;
		case ($urandom_range(7))
			0, 1: v = $urandom_range(8) - 4;
			2: begin
				case ($urandom_range(3))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Remove held values until empty (a few misses on the way), then remove
	// from the empty store.
	task automatic drain_store(inout int done);
		logic [tksm_pkg::IN_VALUE_BITS-1:0] v;
		while (tracker.held_n > 0) begin
			if ($urandom_range(7) == 0) v = pick_value();
			else v = tracker.ranked[$urandom_range(tracker.held_n - 1)];
			send_item(tksm_pkg::FUNC_REMOVE, v);
			done++;
		end
		repeat ($urandom_range(1, 2)) begin
			send_item(tksm_pkg::FUNC_REMOVE, pick_value());
			done++;
		end
	endtask

	// Random part: runs of fill-to-full, extreme fill, drain and churn.
	task automatic run_random(input int items);
		int                                 done;
		logic [tksm_pkg::IN_VALUE_BITS-1:0] extreme;
		done = 0;
		while (done < items) begin
			case ($urandom_range(3))
				0: begin
					// fill up, then knock on the full store
					while (tracker.held_n < DEPTH) begin
						send_item(tksm_pkg::FUNC_INSERT, pick_value());
						done++;
					end
					repeat ($urandom_range(1, 3)) begin
						send_item(tksm_pkg::FUNC_INSERT, pick_value());
						done++;
					end
				end
				1: begin
					// empty, then fill with one extreme to reach the sum limits
					extreme = $urandom_range(1) ? VAL_MAX : VAL_MIN;
					drain_store(done);
					while (tracker.held_n < DEPTH) begin
						send_item(tksm_pkg::FUNC_INSERT, extreme);
						done++;
					end
					send_item(tksm_pkg::FUNC_INSERT, extreme);
					done++;
				end
				2: drain_store(done);
				default: begin
					repeat (24) begin
						if ($urandom_range(1))
							send_item(tksm_pkg::FUNC_INSERT, pick_value());
						else if (tracker.held_n > 0 && $urandom_range(3) != 0)
							send_item(tksm_pkg::FUNC_REMOVE,
								tracker.ranked[$urandom_range(tracker.held_n - 1)]);
						else
							send_item(tksm_pkg::FUNC_REMOVE, pick_value());
						done++;
					end
				end
			endcase
		end
	endtask

	initial begin
		int k_plan[6];
		tracker = new();
		// k per phase: both extremes, small, random, one, back to full width
		k_plan = '{64, 0, 2, $urandom_range(3, 63), 1, 64};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset value of k: empty store, extremes, duplicates,
		// misses.
		send_item(tksm_pkg::FUNC_REMOVE, 32'd5);
		send_item(tksm_pkg::FUNC_INSERT, '0);
		send_item(tksm_pkg::FUNC_INSERT, VAL_MAX);
		send_item(tksm_pkg::FUNC_INSERT, VAL_MIN);
		send_item(tksm_pkg::FUNC_INSERT, '1);
		send_item(tksm_pkg::FUNC_INSERT, VAL_MAX);
		send_item(tksm_pkg::FUNC_REMOVE, 32'd12345);
		send_item(tksm_pkg::FUNC_REMOVE, VAL_MAX);
		send_item(tksm_pkg::FUNC_REMOVE, VAL_MIN);
		send_item(tksm_pkg::FUNC_INSERT, 32'd1);
		send_item(tksm_pkg::FUNC_INSERT, 32'd1);
		send_item(tksm_pkg::FUNC_REMOVE, 32'd1);
		send_item(tksm_pkg::FUNC_REMOVE, '0);
		send_item(tksm_pkg::FUNC_REMOVE, '1);
		send_item(tksm_pkg::FUNC_REMOVE, VAL_MAX);
		send_item(tksm_pkg::FUNC_REMOVE, 32'd1);
		send_item(tksm_pkg::FUNC_REMOVE, VAL_MIN);

		for (int phase = 0; phase < 6; phase++) begin
			// sender light / receiver heavy, then swapped, then no idling
			if (phase == 2) begin
				send_idle_pct = 65;
				recv_idle_pct = 14;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_top_count(k_plan[phase]);
			// the last run of a phase can overshoot the item count
			run_random(35);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.fail_count == 0) begin
			$display("top_k_sum_multiset regression: pass");
		end else begin
			$display("top_k_sum_multiset regression: fail");
		end
		$finish;
	end

endmodule

[top_k_sum_multiset.f]
hw/rtl/tksm_pkg.sv
hw/rtl/tksm_cell.sv
hw/rtl/top_k_sum_multiset.sv
verif/tb_top_k_sum_multiset.sv
